>>> sv/woct_pkg.sv
package woct_pkg;

  // Table geometry.
  localparam int Capacity = 16;
  localparam int IdxW     = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int CntW     = $clog2(Capacity + 1);

  // Field widths of the request and response beats.
  localparam int KeyW  = 32;
  localparam int WgtW  = 32;
  localparam int PosW  = 4;
  localparam int OutCntW = 5;

  // Request type codes.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic            look;     // An add beat is accepted this cycle.
    logic            move;     // Reorder step for an add that touches an entry.
    logic            miss;     // No cell holds the requested key.
    logic [KeyW-1:0] req_key;  // Key of the beat being accepted.
    logic [KeyW-1:0] new_key;  // Key of the entry being placed.
    logic [WgtW-1:0] new_w;    // Updated weight of the entry being placed.
  } woct_ctl_t;

  // Data handed from one cell to the next one down the rank order.
  typedef struct packed {
    logic            seen;  // The requested key sits at this rank or above.
    logic            ge;    // Entry ranks above the touched one and stays ahead.
    logic [KeyW-1:0] key;
    logic [WgtW-1:0] weight;
  } woct_link_t;

endpackage

>>> sv/woct_if.sv
// Request channel.
interface woct_req_if;
  import woct_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [KeyW-1:0] partner_key;
  logic [WgtW-1:0] add_weight;

  modport source (output valid, req_type, partner_key, add_weight, input ready);
  modport sink   (input valid, req_type, partner_key, add_weight, output ready);
endinterface

// Response channel.
interface woct_rsp_if;
  import woct_pkg::*;

  logic               valid;
  logic               ready;
  logic [PosW-1:0]    final_position;
  logic               was_new;
  logic               was_dropped;
  logic [WgtW-1:0]    entry_weight;
  logic [OutCntW-1:0] entry_count;
  logic [OutCntW-1:0] peak_count;

  modport source (output valid, final_position, was_new, was_dropped, entry_weight,
                  entry_count, peak_count, input ready);
  modport sink   (input valid, final_position, was_new, was_dropped, entry_weight,
                  entry_count, peak_count, output ready);
endinterface

>>> sv/weight_ordered_contact_table_unit.sv
// Weight-ordered contact table.
// Requests arrive on req_i (valid/ready). An add beat looks up partner_key,
// adds add_weight to its entry with saturation or appends a new entry, and
// moves the entry ahead of every entry of strictly smaller weight; a full
// table drops a new key. A clear beat records the peak entry count and
// empties the table. Every request produces exactly one beat on rsp_o.
// The table is a row of cells, one per rank. In the accept cycle all cells
// compare the key in parallel and the updated weight is formed; in the next
// cycle every cell decides locally whether to keep, shift down or take the
// touched entry, and the response is registered. No new request is taken
// until this compare-then-reorder sequence over the cell row is done.
// The response register lets a new request be accepted in the cycle in which
// the previous response is taken; if the receiver stalls, the next request is
// held off until the pending response is taken.
// Reset empties the table and clears the peak count; no sweep is needed.
module weight_ordered_contact_table_unit import woct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  woct_req_if.sink    req_i,
  woct_rsp_if.source  rsp_o
);

  typedef enum logic {
    ST_IDLE,
    ST_MOVE
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] peak_q;
  logic            clr_q;
  logic            new_q;
  logic            drop_q;
  logic [KeyW-1:0] key_q;
  logic [WgtW-1:0] new_w_q;

  logic               out_valid_q;
  logic [PosW-1:0]    out_pos_q;
  logic               out_new_q;
  logic               out_drop_q;
  logic [WgtW-1:0]    out_w_q;
  logic [OutCntW-1:0] out_cnt_q;
  logic [OutCntW-1:0] out_peak_q;

  woct_ctl_t        ctl;
  woct_link_t       link [Capacity+1];
  logic [Capacity-1:0] hit_vec;
  logic [Capacity-1:0] ins_vec;
  logic [WgtW-1:0]  hit_w [Capacity];
  logic             accept;
  logic             any_hit;
  logic             full;
  logic [WgtW-1:0]  hit_weight;
  logic [WgtW:0]    sum;
  logic [WgtW-1:0]  upd_w;
  logic [IdxW-1:0]  ins_pos;
  logic [CntW-1:0]  fill_next;
  logic [CntW-1:0]  peak_next;

  // Handshake: a request is taken when idle and the response slot frees up.
  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (fill_q == CntW'(Capacity));

  // Hit summary and updated weight from the parallel compare.
  always_comb begin
    hit_weight = '0;
    for (int j = 0; j < Capacity; j++) begin
      hit_weight = hit_weight | hit_w[j];
    end
  end
  assign any_hit = |hit_vec;
  assign sum     = {1'b0, hit_weight} + {1'b0, req_i.add_weight};
  assign upd_w   = sum[WgtW] ? '1 : sum[WgtW-1:0];

  // Rank of the cell that takes the touched entry.
  always_comb begin
    ins_pos = '0;
    for (int j = 0; j < Capacity; j++) begin
      if (ins_vec[j]) begin
        ins_pos = ins_pos | IdxW'(j);
      end
    end
  end

  assign ctl = '{
    look:    accept && (req_i.req_type == REQ_ADD),
    move:    (state_q == ST_MOVE) && !clr_q && !drop_q,
    miss:    !any_hit,
    req_key: req_i.partner_key,
    new_key: key_q,
    new_w:   new_w_q
  };

  // Row of cells, rank 0 first; rank 0 sees a neighbor that always stays ahead.
  assign link[0] = '{seen: 1'b0, ge: 1'b1, key: '0, weight: '0};

  for (genvar j = 0; j < Capacity; j++) begin : g_cell
    woct_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .occ_i     (fill_q > CntW'(j)),
      .at_fill_i (fill_q == CntW'(j)),
      .link_i    (link[j]),
      .link_o    (link[j+1]),
      .hit_o     (hit_vec[j]),
      .hit_w_o   (hit_w[j]),
      .ins_o     (ins_vec[j])
    );
  end

  // Counts after the request completes.
  always_comb begin
    fill_next = fill_q;
    peak_next = peak_q;
    if (clr_q) begin
      fill_next = '0;
      if (fill_q > peak_q) begin
        peak_next = fill_q;
      end
    end else if (new_q) begin
      fill_next = fill_q + CntW'(1);
    end
  end

  // Sequencer, counters and response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      peak_q      <= '0;
      clr_q       <= 1'b0;
      new_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            clr_q   <= (req_i.req_type == REQ_CLEAR);
            new_q   <= (req_i.req_type == REQ_ADD) && !any_hit && !full;
            drop_q  <= (req_i.req_type == REQ_ADD) && !any_hit && full;
            key_q   <= req_i.partner_key;
            new_w_q <= upd_w;
            state_q <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          fill_q      <= fill_next;
          peak_q      <= peak_next;
          out_valid_q <= 1'b1;
          out_new_q   <= new_q;
          out_drop_q  <= drop_q;
          out_cnt_q   <= OutCntW'(fill_next);
          out_peak_q  <= OutCntW'(peak_next);
          if (clr_q || drop_q) begin
            out_pos_q <= '0;
            out_w_q   <= '0;
          end else begin
            out_pos_q <= PosW'(ins_pos);
            out_w_q   <= new_w_q;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.final_position = out_pos_q;
  assign rsp_o.was_new        = out_new_q;
  assign rsp_o.was_dropped    = out_drop_q;
  assign rsp_o.entry_weight   = out_w_q;
  assign rsp_o.entry_count    = out_cnt_q;
  assign rsp_o.peak_count     = out_peak_q;

  // The fill count never exceeds the table size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(Capacity))
    else $error("fill count exceeds capacity");

  // At most one cell takes the touched entry.
  a_ins_onehot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ins_vec))
    else $error("more than one cell takes the touched entry");

  // A reorder step for a stored entry always finds exactly one slot.
  a_ins_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.move |-> $onehot(ins_vec))
    else $error("touched entry found no slot");

  // Every accepted request yields a response, registered at the end of its reorder step.
  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##1 rsp_o.valid)
    else $error("response missing after request");

  // No request is taken while a reorder step is in progress.
  a_no_accept_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE) |-> !req_i.ready)
    else $error("request accepted during reorder");

endmodule

>>> sv/woct_cell.sv
// One rank of the table: holds a key and its weight, matches the request key,
// and during a reorder step either keeps its entry, takes the entry of the
// rank above, or takes the touched entry.
module woct_cell import woct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  woct_ctl_t       ctl_i,
  input  logic            occ_i,      // Rank is below the fill count.
  input  logic            at_fill_i,  // Rank equals the fill count.
  input  woct_link_t      link_i,
  output woct_link_t      link_o,
  output logic            hit_o,
  output logic [WgtW-1:0] hit_w_o,
  output logic            ins_o
);

  logic [KeyW-1:0] key_q;
  logic [WgtW-1:0] weight_q;
  logic            above_q, above_d;
  logic            at_pos_q, at_pos_d;
  logic            seen;
  logic            ge;
  logic            region;
  logic            from_prev;
  logic            ins;

  // Key match against the incoming beat.
  assign hit_o   = occ_i && (key_q == ctl_i.req_key);
  assign hit_w_o = hit_o ? weight_q : '0;
  assign seen    = link_i.seen | hit_o;

  // Rank relative to the touched entry, latched when the beat is accepted.
  assign above_d  = occ_i & ~seen;
  assign at_pos_d = hit_o | (ctl_i.miss & at_fill_i);

  // Placement: entries of smaller weight slide down one rank.
  assign ge        = above_q && (weight_q >= ctl_i.new_w);
  assign region    = above_q | at_pos_q;
  assign from_prev = region & ~link_i.ge;
  assign ins       = region & link_i.ge & ~ge;
  assign ins_o     = ctl_i.move & ins;

  assign link_o = '{seen: seen, ge: ge, key: key_q, weight: weight_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q  <= 1'b0;
      at_pos_q <= 1'b0;
    end else if (ctl_i.look) begin
      above_q  <= above_d;
      at_pos_q <= at_pos_d;
    end
  end

  // Entry storage; contents are only meaningful below the fill count.
  always_ff @(posedge clk_i) begin
    if (ctl_i.move) begin
      if (from_prev) begin
        key_q    <= link_i.key;
        weight_q <= link_i.weight;
      end else if (ins) begin
        key_q    <= ctl_i.new_key;
        weight_q <= ctl_i.new_w;
      end
    end
  end

endmodule

>>> tb/contact_rank_checker.sv
// Watches both channels of the contact table, keeps its own copy of the table,
// predicts the response to every accepted request and compares field by field.
module contact_rank_checker import woct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  woct_req_if         req_i,
  woct_rsp_if         rsp_i,
  output int          fail_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosW-1:0]    pos;
    logic               fresh;
    logic               dropped;
    logic [WgtW-1:0]    weight;
    logic [OutCntW-1:0] count;
    logic [OutCntW-1:0] peak;
  } rank_update_t;

  // Shadow copy of the table, sorted by weight in descending order.
  logic [KeyW-1:0] key_tab [Capacity];
  logic [WgtW-1:0] wgt_tab [Capacity];
  int unsigned     fill_level = 0;
  int unsigned     peak_level = 0;

  rank_update_t    rank_updates_q [$];

  // Applies one request to the shadow table and returns the response it causes.
  function automatic rank_update_t apply_request(input logic            rtype,
                                                 input logic [KeyW-1:0] key,
                                                 input logic [WgtW-1:0] add_w);
    rank_update_t    res;
    int unsigned     slot;
    bit              hit;
    logic [WgtW:0]   sum;
    logic [KeyW-1:0] tk;
    logic [WgtW-1:0] tw;
    res  = '0;
    slot = 0;
    hit  = 1'b0;
    if (rtype == REQ_CLEAR) begin
      if (peak_level < fill_level) peak_level = fill_level;
      fill_level = 0;
    end else begin
      // Only the first match in rank order counts.
      for (int i = 0; i < fill_level; i++) begin
        if (!hit && key_tab[i] == key) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        sum = {1'b0, wgt_tab[slot]} + {1'b0, add_w};
        wgt_tab[slot] = sum[WgtW] ? '1 : sum[WgtW-1:0];
      end else if (fill_level < Capacity) begin
        slot          = fill_level;
        key_tab[slot] = key;
        wgt_tab[slot] = add_w;
        fill_level++;
        res.fresh = 1'b1;
      end else begin
        res.dropped = 1'b1;
      end
      // Bubble the touched entry past every entry of strictly smaller weight.
      if (!res.dropped) begin
        while (slot > 0 && wgt_tab[slot] > wgt_tab[slot-1]) begin
          tk              = key_tab[slot];
          tw              = wgt_tab[slot];
          key_tab[slot]   = key_tab[slot-1];
          wgt_tab[slot]   = wgt_tab[slot-1];
          key_tab[slot-1] = tk;
          wgt_tab[slot-1] = tw;
          slot--;
        end
        res.pos    = PosW'(slot);
        res.weight = wgt_tab[slot];
      end
    end
    res.count = OutCntW'(fill_level);
    res.peak  = OutCntW'(peak_level);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // Requests are predicted as they are accepted; responses are compared in order.
  always @(posedge clk_i or negedge rst_ni) begin : track_beats
    rank_update_t exp_r;
    if (!rst_ni) begin
      fill_level    = 0;
      peak_level    = 0;
      rank_updates_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        rank_updates_q.push_back(apply_request(req_i.req_type, req_i.partner_key,
                                               req_i.add_weight));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (rank_updates_q.size() == 0) begin
          $error("response beat arrived with no request outstanding");
          fail_count_o++;
        end else begin
          exp_r = rank_updates_q.pop_front();
          check_field("final_position", exp_r.pos,     rsp_i.final_position);
          check_field("was_new",        exp_r.fresh,   rsp_i.was_new);
          check_field("was_dropped",    exp_r.dropped, rsp_i.was_dropped);
          check_field("entry_weight",   exp_r.weight,  rsp_i.entry_weight);
          check_field("entry_count",    exp_r.count,   rsp_i.entry_count);
          check_field("peak_count",     exp_r.peak,    rsp_i.peak_count);
        end
      end
      outstanding_o = rank_updates_q.size();
    end
  end

endmodule

>>> tb/weight_ordered_contact_table_unit_tb.sv
module weight_ordered_contact_table_unit_tb import woct_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          quiet = 1'b0;
  int          fail_count;
  int unsigned outstanding;

  logic [KeyW-1:0] key_pool [24];

  woct_req_if req ();
  woct_rsp_if rsp ();

  weight_ordered_contact_table_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  contact_rank_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req),
    .rsp_i         (rsp),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idle length: mostly none or short, now and then long, none in a quiet stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drives one request beat after an optional idle gap and waits for acceptance.
  task automatic send_request(input logic rtype, input logic [KeyW-1:0] key,
                              input logic [WgtW-1:0] add_w);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      req.valid <= 1'b0;
    end
    @(negedge clk);
    req.valid       <= 1'b1;
    req.req_type    <= rtype;
    req.partner_key <= key;
    req.add_weight  <= add_w;
    do @(posedge clk); while (!req.ready);
  endtask

  // Receiver stalls: random stall runs separated by short ready runs.
  initial begin : rsp_stalls
    int unsigned stall;
    rsp.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        rsp.ready <= 1'b0;
      end
      @(negedge clk);
      rsp.ready <= 1'b1;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned r;
    logic [KeyW-1:0] key;
    logic [WgtW-1:0] add_w;
    req.valid       = 1'b0;
    req.req_type    = REQ_ADD;
    req.partner_key = '0;
    req.add_weight  = '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extreme keys, zero weight, a tie, and saturation of an entry.
    send_request(REQ_ADD, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_ADD, 32'hFFFF_FFFF, 32'h0001_0000);
    send_request(REQ_ADD, 32'h0000_0000, 32'h0001_0000);
    send_request(REQ_ADD, 32'h8000_0001, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h8000_0001, 32'h0000_0001);
    send_request(REQ_ADD, 32'h8000_0001, 32'hFFFF_FFFF);
    send_request(REQ_CLEAR, $urandom(), $urandom());
    // Fill the table with rising weights, so each new entry climbs to the top.
    for (int i = 0; i < Capacity; i++) begin
      send_request(REQ_ADD, 32'h0000_0100 + i, i * 32'h0000_0100);
    end
    // A new key against a full table is dropped; a hit still works.
    send_request(REQ_ADD, 32'h7FFF_FFFE, 32'h0000_0005);
    send_request(REQ_ADD, 32'h0000_0100, 32'h0000_0000);
    send_request(REQ_CLEAR, $urandom(), $urandom());

    // Random traffic: mostly keys from a small pool so hits, ties and full tables occur.
    for (int n = 0; n < 500; n++) begin
      quiet = (n >= 200 && n < 280);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(REQ_CLEAR, $urandom(), $urandom());
      end else begin
        key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 23)] : $urandom();
        r = $urandom_range(0, 99);
        if (r < 25)      add_w = $urandom_range(0, 32'h0000_FFFF);
        else if (r < 55) add_w = $urandom_range(0, 16) << 16;
        else if (r < 75) add_w = $urandom();
        else if (r < 85) add_w = '0;
        else             add_w = 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
        send_request(REQ_ADD, key, add_w);
      end
    end
    quiet = 1'b0;
    @(negedge clk);
    req.valid <= 1'b0;

    // Drain the outstanding responses, then allow a few more cycles.
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
sv/woct_pkg.sv
sv/woct_if.sv
sv/woct_cell.sv
sv/weight_ordered_contact_table_unit.sv
tb/contact_rank_checker.sv
tb/weight_ordered_contact_table_unit_tb.sv
